### src/assert_macros.svh
// Assertion macros for the redirect table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### src/art_pkg.sv
// Types and constants for the address redirect table.
package art_pkg;
	localparam int TableEntriesDef = 64;
	localparam int ComparatorSlotsDef = 6;
	localparam int AddressBitsDef = 39;
	localparam int AddrW = 64;
	localparam int StatusW = 3;
	localparam int CountW = 7;
	localparam int SlotOutW = 3;

	typedef enum logic [1:0] {
		OP_INSTALL = 2'd0,
		OP_UNINSTALL = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_ZERO = 3'd1,
		ST_DUP = 3'd2,
		ST_FULL = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_NOMATCH = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCANCHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_FINISH,
		S_OUT
	} state_t;
endpackage

### src/art_table.sv
// Entry memory: one write port, one registered read port.
module art_table import art_pkg::*; #(
	parameter int TABLE_ENTRIES = TableEntriesDef,
	parameter int COMPARATOR_SLOTS = ComparatorSlotsDef,
	parameter int ADDRESS_BITS = AddressBitsDef,
	localparam int IdxW = $clog2(TABLE_ENTRIES),
	localparam int SlotW = $clog2(COMPARATOR_SLOTS + 1),
	localparam int EntW = ADDRESS_BITS + AddrW + 1 + SlotW
) (
	input  logic            clk,
	input  logic            we,
	input  logic [IdxW-1:0] waddr,
	input  logic [EntW-1:0] wdata,
	input  logic [IdxW-1:0] raddr,
	output logic [EntW-1:0] rdata
);
	logic [EntW-1:0] mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### src/address_redirect_table.sv
// Top level of the address redirect table: sequencer, slot owners and entry store.
//
// An ordered table of up to TABLE_ENTRIES redirect entries kept in a memory with
// one write port and one registered read port (one write, one registered read
// per cycle), plus COMPARATOR_SLOTS comparator slots held in flops. One item is
// handled at a time; s_tready is low while it is in work. Install, lookup and
// uninstall walk the table one entry at a time, reading it in S_SCAN and
// comparing it in S_SCANCHK. Install stops at a duplicate and lookup at the
// first hit. Uninstall hands over at its target to moving each later entry down
// one place, reading it in S_SHIFT_RD and writing it back in S_SHIFT_WR.
// A zero-argument install, a paused lookup and the unused opcode skip the walk
// and pass from S_SCAN straight to S_FINISH. The next item can be taken in the
// cycle after the result leaves.
// Every item gives exactly one result item on the master side, held until
// taken. The slot owner indices are renumbered in one step after compaction.
// matching_enabled (reset 1) gates lookups; write it only while idle.
`include "assert_macros.svh"
module address_redirect_table import art_pkg::*; #(
	parameter int TABLE_ENTRIES = TableEntriesDef,
	parameter int COMPARATOR_SLOTS = ComparatorSlotsDef,
	parameter int ADDRESS_BITS = AddressBitsDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode[1:0], address[65:2], redirect_to[129:66], zeros to 135
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], redirect_hit[3], redirect_address[67:4], assigned_slot[70:68],
	// entry_count[77:71], zeros to 79
	output logic [79:0]  m_tdata
);
	localparam int IdxW = $clog2(TABLE_ENTRIES);
	localparam int CntW = $clog2(TABLE_ENTRIES + 1);
	localparam int SlotW = $clog2(COMPARATOR_SLOTS + 1);
	localparam int EntW = ADDRESS_BITS + AddrW + 1 + SlotW;

	state_t state_q, state_d;
	logic              match_en_q;
	logic [1:0]        op_q;
	logic [ADDRESS_BITS-1:0] tgt_q;
	logic [AddrW-1:0]  repl_q;
	logic              zero_q;
	logic [CntW-1:0]   total_q;
	logic [CntW-1:0]   idx_q;
	logic [IdxW-1:0]   pos_idx_q;
	logic [StatusW-1:0] status_q;
	logic              hit_q;
	logic [AddrW-1:0]  raddr_q;
	logic [SlotOutW-1:0] aslot_q;
	logic [COMPARATOR_SLOTS-1:0] slot_used_q;
	logic [IdxW-1:0]   slot_owner_q [COMPARATOR_SLOTS];

	logic            we;
	logic [IdxW-1:0] waddr, rd_addr;
	logic [EntW-1:0] wdata, rdata;

	logic [ADDRESS_BITS-1:0] rd_tgt;
	logic [AddrW-1:0]        rd_repl;
	logic                    rd_has;
	logic [SlotW-1:0]        rd_slot;
	assign {rd_slot, rd_has, rd_repl, rd_tgt} = rdata;

	art_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES), .COMPARATOR_SLOTS(COMPARATOR_SLOTS),
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(rd_addr), .rdata(rdata)
	);

	// lowest free slot
	logic             free_found;
	logic [SlotW-1:0] free_slot;
	always_comb begin
		free_found = 1'b0;
		free_slot = SlotW'(COMPARATOR_SLOTS);
		for (int s = COMPARATOR_SLOTS - 1; s >= 0; s--) begin
			if (!slot_used_q[s]) begin
				free_found = 1'b1;
				free_slot = SlotW'(s);
			end
		end
	end

	logic in_acc, out_acc, tgt_eq, more, stop;
	assign in_acc = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign tgt_eq = (rd_tgt == tgt_q);
	assign more = (idx_q < total_q);
	// rejected or idle ops skip the walk
	assign stop = (op_q == OP_NONE) || (op_q == OP_INSTALL && zero_q) ||
		(op_q == OP_LOOKUP && !match_en_q);
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = {2'b0, 7'(total_q), aslot_q, raddr_q, hit_q, status_q};

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = idx_q[IdxW-1:0];
		wdata = {free_slot, free_found, repl_q, tgt_q};
		rd_addr = idx_q[IdxW-1:0];
		case (state_q)
			S_IDLE: if (in_acc) state_d = S_SCAN;
			S_SCAN: state_d = (more && !stop) ? S_SCANCHK : S_FINISH;
			// an uninstall hit switches the walk into compaction
			S_SCANCHK: state_d = (op_q == OP_UNINSTALL && tgt_eq) ? S_SHIFT_RD : S_SCAN;
			S_SHIFT_RD: state_d = more ? S_SHIFT_WR : S_FINISH;
			S_SHIFT_WR: begin
				we = 1'b1;
				waddr = IdxW'(idx_q - CntW'(1));
				wdata = rdata;
				state_d = S_SHIFT_RD;
			end
			S_FINISH: begin
				we = (op_q == OP_INSTALL) && (status_q == ST_OK);
				waddr = total_q[IdxW-1:0];
				state_d = S_OUT;
			end
			S_OUT: if (out_acc) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			match_en_q <= 1'b1;
			total_q <= '0;
			slot_used_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) match_en_q <= cfg_wdata;
			case (state_q)
				S_FINISH: begin
					if (op_q == OP_INSTALL && status_q == ST_OK) begin
						total_q <= total_q + CntW'(1);
						if (free_found) slot_used_q[free_slot] <= 1'b1;
					end
					if (op_q == OP_UNINSTALL && status_q == ST_OK) begin
						total_q <= total_q - CntW'(1);
					end
				end
				S_SCANCHK: begin
					if (op_q == OP_UNINSTALL && tgt_eq && rd_has &&
							rd_slot < SlotW'(COMPARATOR_SLOTS))
						slot_used_q[rd_slot[$clog2(COMPARATOR_SLOTS > 1 ?
							COMPARATOR_SLOTS : 2)-1:0]] <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_acc) begin
				op_q <= s_tdata[1:0];
				tgt_q <= s_tdata[ADDRESS_BITS+1:2];
				repl_q <= s_tdata[129:66];
				zero_q <= (s_tdata[65:2] == '0) || (s_tdata[129:66] == '0);
				idx_q <= '0;
				hit_q <= 1'b0;
				raddr_q <= '0;
				aslot_q <= SlotOutW'(COMPARATOR_SLOTS);
				case (s_tdata[1:0])
					OP_INSTALL:   status_q <= (s_tdata[65:2] == '0 || s_tdata[129:66] == '0)
						? ST_ZERO : ST_OK;
					OP_UNINSTALL: status_q <= ST_NOTFOUND;
					OP_LOOKUP:    status_q <= ST_NOMATCH;
					default:      status_q <= ST_OK;
				endcase
			end
			S_SCAN: begin
				if (stop)
					idx_q <= total_q;
				if (!more && op_q == OP_INSTALL && status_q == ST_OK) begin
					if (total_q >= CntW'(TABLE_ENTRIES)) status_q <= ST_FULL;
				end
			end
			S_SCANCHK: begin
				idx_q <= idx_q + CntW'(1);
				if (tgt_eq) begin
					case (op_q)
						OP_INSTALL: begin
							status_q <= ST_DUP;
							idx_q <= total_q;
						end
						OP_LOOKUP: if (rd_has) begin
							status_q <= ST_OK;
							hit_q <= 1'b1;
							raddr_q <= rd_repl;
							idx_q <= total_q;
						end
						OP_UNINSTALL: begin
							status_q <= ST_OK;
							pos_idx_q <= idx_q[IdxW-1:0];
						end
						default: ;
					endcase
				end
			end
			S_SHIFT_WR: idx_q <= idx_q + CntW'(1);
			S_FINISH: begin
				if (op_q == OP_INSTALL && status_q == ST_OK && free_found) begin
					aslot_q <= SlotOutW'(free_slot);
					slot_owner_q[free_slot] <= total_q[IdxW-1:0];
				end
				if (op_q == OP_UNINSTALL && status_q == ST_OK) begin
					for (int s = 0; s < COMPARATOR_SLOTS; s++)
						if (slot_used_q[s] && slot_owner_q[s] > pos_idx_q)
							slot_owner_q[s] <= slot_owner_q[s] - IdxW'(1);
				end
			end
			default: ;
		endcase
	end

	`ASSERT_CLK(a_total_range, clk, arst_n, total_q <= CntW'(TABLE_ENTRIES),
		"entry count above table size")
	`ASSERT_NEVER(a_out_in, clk, arst_n, m_tvalid && s_tready,
		"accepting while a result waits")
	`ASSERT_CLK(a_hit_ok, clk, arst_n, m_tvalid && hit_q |-> status_q == ST_OK,
		"hit with bad status")
endmodule

### test/address_redirect_table_tb.sv
// Self-checking testbench for the address redirect table.
`timescale 1ns / 1ps
module address_redirect_table_tb;
	import art_pkg::*;

	localparam int NumEntries = 64;
	localparam int NumSlots = 6;
	localparam logic [63:0] TargetMask = 64'h0000_007F_FFFF_FFFF;
	localparam int CycleLimit = 2000000;

	// One expected result item
	typedef struct packed {
		logic [2:0]  status;
		logic        hit;
		logic [63:0] raddr;
		logic [2:0]  slot;
		logic [6:0]  count;
	} redirect_result_t;

	// Scoreboard: mirrors the table and queues the expected results
	class redirect_scoreboard;
		logic [63:0] tgt[NumEntries];
		logic [63:0] repl[NumEntries];
		bit          has_slot[NumEntries];
		int          slot_of[NumEntries];
		int          owner[NumSlots];
		bit          used[NumSlots];
		int          total;
		bit          enabled;
		redirect_result_t pending[$];
		int          errors;

		function void clear();
			total = 0;
			enabled = 1;
			errors = 0;
			foreach (used[s]) used[s] = 0;
			pending.delete();
		endfunction

		function int find_target(logic [63:0] m);
			for (int i = 0; i < total; i++)
				if (tgt[i] == m) return i;
			return total;
		endfunction

		// Predict one accepted item and queue its result
		function void note_item(op_t op, logic [63:0] addr, logic [63:0] rep);
			redirect_result_t r;
			logic [63:0] m;
			int p;
			m = addr & TargetMask;
			r = '{status: ST_OK, hit: 0, raddr: 0, slot: 3'(NumSlots), count: 0};
			case (op)
				OP_INSTALL: begin
					if (addr == 0 || rep == 0) r.status = ST_ZERO;
					else if (find_target(m) < total) r.status = ST_DUP;
					else if (total >= NumEntries) r.status = ST_FULL;
					else begin
						p = total;
						tgt[p] = m;
						repl[p] = rep;
						has_slot[p] = 0;
						slot_of[p] = 0;
						for (int s = 0; s < NumSlots; s++) begin
							if (!used[s]) begin
								used[s] = 1;
								owner[s] = p;
								has_slot[p] = 1;
								slot_of[p] = s;
								r.slot = 3'(s);
								break;
							end
						end
						total++;
					end
				end
				OP_UNINSTALL: begin
					p = find_target(m);
					if (p >= total) r.status = ST_NOTFOUND;
					else begin
						if (has_slot[p]) used[slot_of[p]] = 0;
						for (int i = p; i + 1 < total; i++) begin
							tgt[i] = tgt[i+1];
							repl[i] = repl[i+1];
							has_slot[i] = has_slot[i+1];
							slot_of[i] = slot_of[i+1];
						end
						total--;
						for (int s = 0; s < NumSlots; s++)
							if (used[s] && owner[s] > p) owner[s]--;
					end
				end
				OP_LOOKUP: begin
					r.status = ST_NOMATCH;
					if (enabled) begin
						for (int i = 0; i < total; i++) begin
							if (has_slot[i] && tgt[i] == m) begin
								r.status = ST_OK;
								r.hit = 1;
								r.raddr = repl[i];
								break;
							end
						end
					end
				end
				default: ;
			endcase
			r.count = 7'(total);
			pending.push_back(r);
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(logic [79:0] d);
			redirect_result_t e;
			if (pending.size() == 0) begin
				$error("result item with nothing expected: %h", d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[2:0] !== e.status) begin
				$error("status expected %0d actual %0d", e.status, d[2:0]);
				errors++;
			end
			if (d[3] !== e.hit) begin
				$error("redirect_hit expected %0d actual %0d", e.hit, d[3]);
				errors++;
			end
			if (d[67:4] !== e.raddr) begin
				$error("redirect_address expected %h actual %h", e.raddr, d[67:4]);
				errors++;
			end
			if (d[70:68] !== e.slot) begin
				$error("assigned_slot expected %0d actual %0d", e.slot, d[70:68]);
				errors++;
			end
			if (d[77:71] !== e.count) begin
				$error("entry_count expected %0d actual %0d", e.count, d[77:71]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_wdata = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [135:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [79:0] m_tdata;

	redirect_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycles = 0;
	logic [63:0] known_targets[$];

	always #4 clk = ~clk;

	address_redirect_table u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("address_redirect_table verification failed");
			$finish;
		end
	end

	// Receiver: random stall, check each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Send one item, with random idle cycles before it; tvalid stays up after
	// the accept until the next idle cycle or drain drops it
	task automatic send_item(op_t op, logic [63:0] addr, logic [63:0] rep);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {6'b0, rep, addr, op};
		do @(posedge clk); while (!s_tready);
		sb.note_item(op, addr, rep);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// Write the enable register while idle
	task automatic set_matching(bit v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.enabled = v;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Target drawn from a small pool so duplicates and hits happen; high bits are noise
	function automatic logic [63:0] pick_target();
		logic [63:0] a;
		if (known_targets.size() != 0 && $urandom_range(99) < 70)
			a = known_targets[$urandom_range(known_targets.size() - 1)];
		else begin
			a = 64'($urandom_range(200) + 1);
			if ($urandom_range(3) == 0) a = rand64() & TargetMask;
			known_targets.push_back(a);
		end
		return a | ($urandom_range(1) ? {rand64()} & ~TargetMask : 64'd0);
	endfunction

	task automatic random_phase(int n);
		int k;
		logic [63:0] a;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			a = pick_target();
			if ($urandom_range(49) == 0) a = 0;
			if (k < 40)
				send_item(OP_INSTALL, a, ($urandom_range(39) == 0) ? 64'd0 : rand64());
			else if (k < 60) send_item(OP_UNINSTALL, a, rand64());
			else if (k < 97) send_item(OP_LOOKUP, a, rand64());
			else send_item(OP_NONE, rand64(), rand64());
		end
	endtask

	initial begin
		sb.clear();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: zero arguments, slots filling, waiting entries, extremes
		send_item(OP_INSTALL, 64'd0, 64'd5);
		send_item(OP_INSTALL, 64'd5, 64'd0);
		send_item(OP_LOOKUP, 64'd1, 64'd0);
		for (int i = 1; i <= 8; i++)
			send_item(OP_INSTALL, 64'(i), ~64'(i));
		send_item(OP_INSTALL, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_INSTALL, 64'hFFFF_FF80_0000_0003, 64'd1); // duplicate after masking
		send_item(OP_LOOKUP, 64'hAB00_0000_0000_0002, 64'd0);
		send_item(OP_LOOKUP, 64'd7, 64'd0);                       // waiting entry, no hit
		send_item(OP_UNINSTALL, 64'd2, 64'd0);
		send_item(OP_UNINSTALL, 64'd99, 64'd0);
		send_item(OP_INSTALL, 64'd50, 64'hFFFF_FFFF_FFFF_FFFF);   // takes freed slot
		send_item(OP_LOOKUP, 64'd50, 64'd0);
		send_item(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		set_matching(0);
		send_item(OP_LOOKUP, 64'd1, 64'd0);                       // paused
		set_matching(1);
		send_item(OP_LOOKUP, 64'd1, 64'd0);
		// Fill the table to the top, then overflow
		for (int i = 0; i < 58; i++) send_item(OP_INSTALL, 64'(1000 + i), 64'(i + 1));
		send_item(OP_INSTALL, 64'd5000, 64'd1);
		send_item(OP_LOOKUP, 64'd1057, 64'd0);
		for (int i = 0; i < 64; i++)
			send_item(OP_UNINSTALL, sb.total ? sb.tgt[$urandom_range(sb.total - 1)] : 64'd1, 0);

		send_idle_pct = 34;
		recv_idle_pct = 53;
		random_phase(420);
		drain(); // sender holds off until nothing is pending
		set_matching(0);
		random_phase(60);
		set_matching(1);
		send_idle_pct = 53;
		recv_idle_pct = 34;
		random_phase(380);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(250);

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("address_redirect_table verification clean");
		else
			$display("address_redirect_table verification failed");
		$finish;
	end
endmodule
